// File: hw/rtl/mcf_pkg.sv
// Shared types and constants for the message chunk framer.
`default_nettype none
package mcf_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;

    localparam logic [7:0]  CPS_RESET      = 8'd160;
    localparam logic [7:0]  SHORT_RESET    = 8'd20;
    localparam logic [15:0] MAX_CHUNK_QUO  = 16'd255;
    localparam logic [31:0] MSG_ID_RESET   = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_PAYLOAD_SIZE,
        CFG_SHORT_MESSAGE_LIMIT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_RAW,
        MODE_CHUNK,
        MODE_OVF
    } t_mode;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] message_length;
        logic        channel;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_first;
        logic       frame_end;
        logic       out_channel;
        logic       overflow;
        logic       run_last;
    } t_res;

    // One queued transaction: optional 8-byte header plus one final result.
    typedef struct packed {
        logic        hdr;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        chan;
        logic        ovf;
        logic [31:0] msg_id;
        logic [7:0]  chunk_idx;
        logic [7:0]  chunk_tot;
        logic [7:0]  chunk_len;
    } t_cmd;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [7:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

// File: hw/rtl/mcf_if.sv
// Valid/ready channel interfaces for framer input items and output results.
`default_nettype none
interface mcf_in_if;
    import mcf_pkg::*;
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mcf_out_if;
    import mcf_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mcf_div.sv
// Restoring divider, one quotient bit per cycle: 16-bit dividend by 8-bit divisor.
`default_nettype none
module mcf_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mcf_pkg::t_div_req i_req,
    output mcf_pkg::t_div_rsp      o_rsp
);
    import mcf_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [7:0]  r_rem;
    logic [15:0] r_quo;
    logic [7:0]  r_dvs;

    logic [8:0] trial;
    logic [8:0] diff;
    logic       ge;

    always_comb begin
        trial = {r_rem, r_quo[15]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= '0;
            r_dvs  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[7:0] : trial[7:0];
                r_quo <= {r_quo[14:0], ge};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'hF) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

// File: hw/rtl/mcf_front.sv
// Front end: accepts bytes, tracks message and chunk position, issues commands.
`default_nettype none
module mcf_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    mcf_in_if.sink                 i_in,
    input  wire logic [7:0]        i_cps,
    input  wire logic [7:0]        i_short_limit,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output mcf_pkg::t_cmd          o_cmd,
    output mcf_pkg::t_div_req      o_div_req,
    input  wire mcf_pkg::t_div_rsp i_div_rsp
);
    import mcf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    t_state      r_state;
    logic [15:0] r_pos;
    logic [15:0] r_len;
    logic        r_chan;
    logic [7:0]  r_cps;
    t_mode       r_mode;
    logic [7:0]  r_byte;
    logic [7:0]  r_ci;
    logic [7:0]  r_bl;
    logic [7:0]  r_total;
    logic [31:0] r_cur_id;
    logic [31:0] r_next_id;

    logic        accept;
    logic [15:0] len_n;
    logic [7:0]  cps_n;
    logic        raw_n;
    logic        first_in;
    logic        start_div;
    logic        do_step;
    logic        div_ovf;
    logic [7:0]  div_total;
    t_mode       eff_mode;
    logic [15:0] eff_len;
    logic        eff_chan;
    logic [7:0]  eff_cps;
    logic [7:0]  eff_byte;
    logic [7:0]  eff_ci;
    logic [7:0]  eff_bl;
    logic [31:0] eff_id;
    logic [7:0]  eff_total;
    logic        hdr;
    logic [15:0] rem;
    logic [7:0]  clen;
    logic [7:0]  bl_new;
    logic        chunk_end;
    logic [16:0] pos_inc;
    logic        msg_done;

    assign i_in.ready = (r_state == S_IDLE) && !i_q_full;

    always_comb begin
        accept    = i_in.valid && i_in.ready;
        len_n     = (i_in.data.message_length == '0) ? 16'd1 : i_in.data.message_length;
        cps_n     = (i_cps == '0) ? 8'd1 : i_cps;
        raw_n     = len_n <= {8'd0, i_short_limit};
        first_in  = (r_state == S_IDLE) && (r_pos == '0);
        start_div = (r_state == S_IDLE) && accept && (r_pos == '0) && !raw_n;
        do_step   = ((r_state == S_IDLE) && accept && !start_div)
                 || ((r_state == S_PUSH) && !i_q_full);
        div_ovf   = i_div_rsp.quo >= MAX_CHUNK_QUO;
        div_total = i_div_rsp.quo[7:0] + 8'd1;

        if (r_state == S_PUSH) begin
            eff_mode = div_ovf ? MODE_OVF : MODE_CHUNK;
        end else if (first_in) begin
            eff_mode = MODE_RAW;
        end else begin
            eff_mode = r_mode;
        end
        eff_len   = first_in ? len_n : r_len;
        eff_chan  = first_in ? i_in.data.channel : r_chan;
        eff_cps   = r_cps;
        eff_byte  = (r_state == S_PUSH) ? r_byte : i_in.data.data_byte;
        eff_ci    = (r_state == S_PUSH) ? 8'd0 : r_ci;
        eff_bl    = (r_state == S_PUSH) ? 8'd0 : r_bl;
        eff_id    = (r_state == S_PUSH) ? r_next_id : r_cur_id;
        eff_total = (r_state == S_PUSH) ? div_total : r_total;

        // chunk bookkeeping: header opens a chunk when nothing is left in the last one
        hdr       = (eff_bl == '0);
        rem       = eff_len - r_pos;
        clen      = (rem < {8'd0, eff_cps}) ? rem[7:0] : eff_cps;
        bl_new    = (hdr ? clen : eff_bl) - 8'd1;
        chunk_end = (bl_new == '0);

        pos_inc  = {1'b0, r_pos} + 17'd1;
        msg_done = pos_inc >= {1'b0, eff_len};

        o_cmd           = '0;
        o_cmd.chan      = eff_chan;
        o_cmd.data      = eff_byte;
        o_cmd.msg_id    = eff_id;
        o_cmd.chunk_idx = eff_ci;
        o_cmd.chunk_tot = eff_total;
        o_cmd.chunk_len = clen;
        case (eff_mode)
            MODE_RAW: begin
                o_cmd.first = (r_pos == '0);
                o_cmd.last  = (pos_inc == {1'b0, eff_len});
            end
            MODE_CHUNK: begin
                o_cmd.hdr  = hdr;
                o_cmd.last = chunk_end;
            end
            MODE_OVF: begin
                o_cmd.data = '0;
                o_cmd.ovf  = 1'b1;
            end
            default: begin
                o_cmd.data = '0;
            end
        endcase
        o_push = do_step && !((eff_mode == MODE_OVF) && (r_pos != '0));

        o_div_req.start    = start_div;
        o_div_req.dividend = len_n - 16'd1;
        o_div_req.divisor  = cps_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_len     <= '0;
            r_chan    <= 1'b0;
            r_cps     <= '0;
            r_mode    <= MODE_RAW;
            r_ci      <= '0;
            r_bl      <= '0;
            r_total   <= '0;
            r_cur_id  <= '0;
            r_next_id <= MSG_ID_RESET;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start_div) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (start_div || (do_step && first_in)) begin
                r_len  <= len_n;
                r_chan <= i_in.data.channel;
                r_cps  <= cps_n;
            end

            if (do_step) begin
                r_mode <= eff_mode;
                r_pos  <= msg_done ? 16'd0 : pos_inc[15:0];
                if (eff_mode == MODE_CHUNK) begin
                    r_bl <= msg_done ? 8'd0 : bl_new;
                    r_ci <= chunk_end ? (eff_ci + 8'd1) : eff_ci;
                    if (r_state == S_PUSH) begin
                        r_cur_id  <= r_next_id;
                        r_next_id <= r_next_id + 32'd1;
                        r_total   <= div_total;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_byte <= i_in.data.data_byte;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/mcf_queue.sv
// Short command queue between front and back ends.
`default_nettype none
module mcf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mcf_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output mcf_pkg::t_cmd      o_head
);
    import mcf_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/mcf_back.sv
// Back end: expands queued commands into header and payload result bytes.
`default_nettype none
module mcf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire mcf_pkg::t_cmd i_head,
    output logic               o_pop,
    mcf_out_if.source          o_out
);
    import mcf_pkg::*;

    logic                 r_valid;
    t_res                 r_res;
    logic [HDR_CNT_W-1:0] r_hcnt;

    logic in_hdr;
    logic load;
    t_res n_res;
    logic [7:0] hbyte;

    always_comb begin
        case (r_hcnt[2:0])
            3'd0:    hbyte = i_head.msg_id[31:24];
            3'd1:    hbyte = i_head.msg_id[23:16];
            3'd2:    hbyte = i_head.msg_id[15:8];
            3'd3:    hbyte = i_head.msg_id[7:0];
            3'd4:    hbyte = i_head.chunk_idx;
            3'd5:    hbyte = i_head.chunk_tot;
            3'd6:    hbyte = 8'd0;  // chunk length high byte, length never exceeds 255
            default: hbyte = i_head.chunk_len;
        endcase

        in_hdr = i_head.hdr && (r_hcnt < HDR_CNT_W'(HEADER_BYTES));
        load   = i_valid && (!r_valid || o_out.ready);

        n_res.out_channel = i_head.chan;
        if (in_hdr) begin
            n_res.out_byte    = hbyte;
            n_res.frame_first = (r_hcnt == '0);
            n_res.frame_end   = 1'b0;
            n_res.overflow    = 1'b0;
            n_res.run_last    = 1'b0;
        end else begin
            n_res.out_byte    = i_head.data;
            n_res.frame_first = i_head.first;
            n_res.frame_end   = i_head.last;
            n_res.overflow    = i_head.ovf;
            n_res.run_last    = 1'b1;
        end

        o_pop = load && !in_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hcnt  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_hcnt  <= in_hdr ? (r_hcnt + HDR_CNT_W'(1)) : '0;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_res;

endmodule
`default_nettype wire

// File: hw/rtl/message_chunk_framer_top.sv
// Top level of the message chunk framer: config registers and front/queue/back wiring.
`default_nettype none
// Flow: a byte continuing a message goes into the command queue, then into the
//   output register; the first byte of a chunked message holds off the input
//   while the bit-serial chunk-count divider runs and until its command is queued,
//   after which its 8 header bytes and then the byte itself leave via the queue.
// Throughput: one result per cycle out of the back end while the sink is ready;
//   1 item/cycle for raw and mid-chunk bytes while the queue has room.
// Reset: synchronous, active low; registers return to 160/20, message id to 1,
//   queue and output register empty. No clearing pass.
module message_chunk_framer_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    mcf_in_if.sink                                 i_in,
    mcf_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [mcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [mcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mcf_pkg::*;

    // Configuration registers; the front end samples them at the first byte
    // of each message, so writes only take effect on the next message.
    logic [7:0] r_chunk_payload_size;
    logic [7:0] r_short_message_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_payload_size  <= CPS_RESET;
            r_short_message_limit <= SHORT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CHUNK_PAYLOAD_SIZE:  r_chunk_payload_size  <= i_cfg_data;
                CFG_SHORT_MESSAGE_LIMIT: r_short_message_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end -> command queue -> back end. The queue decouples header
    // emission bursts from input acceptance.
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    t_cmd     q_in;
    t_cmd     q_head;
    t_div_req div_req;
    t_div_rsp div_rsp;

    mcf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cps         (r_chunk_payload_size),
        .i_short_limit (r_short_message_limit),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (q_in),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp)
    );

    // Chunk count = (length - 1) / payload size + 1, computed serially.
    mcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    mcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Each queued transaction yields 1 result, or 9 when it opens a chunk.
    mcf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// File: dv/mcf_frame_checker.sv
// Scoreboard for the message chunk framer: predicts every output byte and compares it.
module mcf_frame_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  mcf_pkg::t_item                      i_in_data,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  mcf_pkg::t_res                       i_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [mcf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mcf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import mcf_pkg::*;

    // register copies
    logic [7:0]  cps_reg;
    logic [7:0]  short_reg;

    // framing state
    logic [31:0] next_id;
    logic [31:0] cur_id;
    logic [15:0] pos;
    logic [7:0]  chunk_no;
    logic [7:0]  chunk_cnt;
    logic [7:0]  chunk_left;
    logic [7:0]  cur_chunk_len;

    // per-message latches
    logic [15:0] msg_len;
    logic        msg_chan;
    logic [7:0]  msg_cps;
    t_mode       msg_mode;

    t_res expected_frame_bytes[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input t_res got, input t_res want);
        if (o_fail_count < 50) begin
            $display("%0t check: %s: got %02h f%b e%b c%b o%b l%b, want %02h f%b e%b c%b o%b l%b",
                     $time, what,
                     got.out_byte, got.frame_first, got.frame_end,
                     got.out_channel, got.overflow, got.run_last,
                     want.out_byte, want.frame_first, want.frame_end,
                     want.out_channel, want.overflow, want.run_last);
        end
        o_fail_count++;
    endtask

    task automatic reset_framing();
        cps_reg       = CPS_RESET;
        short_reg     = SHORT_RESET;
        next_id       = MSG_ID_RESET;
        cur_id        = '0;
        pos           = '0;
        chunk_no      = '0;
        chunk_cnt     = '0;
        chunk_left    = '0;
        cur_chunk_len = '0;
        msg_len       = '0;
        msg_chan      = 1'b0;
        msg_cps       = '0;
        msg_mode      = MODE_RAW;
        expected_frame_bytes.delete();
    endtask

    task automatic queue_frame_byte(input logic [7:0] b, input logic first,
                                    input logic frame_last, input logic ovf);
        t_res r;
        r.out_byte    = b;
        r.frame_first = first;
        r.frame_end   = frame_last;
        r.out_channel = msg_chan;
        r.overflow    = ovf;
        r.run_last    = 1'b0;
        expected_frame_bytes.push_back(r);
    endtask

    // One accepted payload byte -> the bytes it puts on the link.
    task automatic frame_byte(input t_item it);
        int          total;
        int          size_before;
        logic [15:0] rem;
        logic [63:0] header;
        t_res        tail;
        size_before = expected_frame_bytes.size();
        if (pos == 16'd0) begin
            msg_len  = (it.message_length == 16'd0) ? 16'd1 : it.message_length;
            msg_chan = it.channel;
            msg_cps  = (cps_reg == 8'd0) ? 8'd1 : cps_reg;
            if (msg_len <= {8'd0, short_reg}) begin
                msg_mode = MODE_RAW;
            end else begin
                total = (int'(msg_len) + int'(msg_cps) - 1) / int'(msg_cps);
                if (total > 255) begin
                    msg_mode = MODE_OVF;
                end else begin
                    msg_mode   = MODE_CHUNK;
                    cur_id     = next_id;
                    next_id    = next_id + 32'd1;
                    chunk_cnt  = total[7:0];
                    chunk_no   = '0;
                    chunk_left = '0;
                end
            end
        end

        case (msg_mode)
            MODE_RAW: begin
                queue_frame_byte(it.data_byte, pos == 16'd0,
                                 {1'b0, pos} + 17'd1 == {1'b0, msg_len}, 1'b0);
            end
            MODE_OVF: begin
                if (pos == 16'd0) queue_frame_byte(8'h00, 1'b0, 1'b0, 1'b1);
            end
            default: begin
                if (chunk_left == 8'd0) begin
                    rem           = msg_len - pos;
                    cur_chunk_len = (rem < {8'd0, msg_cps}) ? rem[7:0] : msg_cps;
                    header        = {cur_id, chunk_no, chunk_cnt, 8'h00, cur_chunk_len};
                    for (int k = 0; k < HEADER_BYTES; k++) begin
                        queue_frame_byte(header[63-8*k -: 8], k == 0, 1'b0, 1'b0);
                    end
                    chunk_left = cur_chunk_len;
                end
                chunk_left = chunk_left - 8'd1;
                queue_frame_byte(it.data_byte, 1'b0, chunk_left == 8'd0, 1'b0);
                if (chunk_left == 8'd0) chunk_no = chunk_no + 8'd1;
            end
        endcase

        pos = pos + 16'd1;
        if (pos >= msg_len) begin
            pos        = '0;
            chunk_left = '0;
        end

        if (expected_frame_bytes.size() > size_before) begin
            tail          = expected_frame_bytes[expected_frame_bytes.size()-1];
            tail.run_last = 1'b1;
            expected_frame_bytes[expected_frame_bytes.size()-1] = tail;
        end
    endtask

    task automatic check_frame_byte(input t_res got);
        t_res want;
        if (expected_frame_bytes.size() == 0) begin
            report_mismatch("output with nothing expected", got, '0);
        end else begin
            want = expected_frame_bytes.pop_front();
            if (got !== want) report_mismatch("wrong output", got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_framing();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CHUNK_PAYLOAD_SIZE:  cps_reg   = i_cfg_data;
                    CFG_SHORT_MESSAGE_LIMIT: short_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) frame_byte(i_in_data);
            if (i_out_valid && i_out_ready) check_frame_byte(i_out_data);
        end
        o_pending = expected_frame_bytes.size();
    end

endmodule

// File: dv/tb_message_chunk_framer_top.sv
// Testbench top for the message chunk framer: stimulus, back-pressure and verdict.
module tb_message_chunk_framer_top;
    import mcf_pkg::*;

    // Quiet time before a register write: covers the chunk-count divider
    // plus a full header burst, since overflow bytes after the first
    // produce nothing and can still be in flight when the queue runs dry.
    localparam int IDLE_SETTLE    = 40;
    // Longest correct stretch without any transaction is roughly settle +
    // config + divider + output stalls; the limit is that many times over.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mcf_in_if  in_ch ();
    mcf_out_if out_ch ();

    int fail_count;
    int pending;
    int idle_pct;       // chance (percent) of starting an idle burst, both sides
    int stall_left;
    int quiet_cycles;
    int framed_items;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    message_chunk_framer_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mcf_frame_checker frame_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Output back-pressure: ready drops in random bursts. With idle_pct at zero
    // the sink takes every byte.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(7, 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: too long without a transaction on either channel is a hang.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_message_chunk_framer_top: FAIL");
            $finish;
        end
    end

    // One input transaction, optionally preceded by an idle burst.
    // Called and returns at a rising edge.
    task automatic send_item(input logic [7:0] b, input logic [15:0] len, input logic ch);
        t_item it;
        it.data_byte      = b;
        it.message_length = len;
        it.channel        = ch;
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Whole message of random bytes. With noisy set, every byte after the
    // first carries junk length/channel, which the block must ignore.
    task automatic send_message(input logic [15:0] len, input logic ch, input bit noisy);
        int          n;
        logic [15:0] len_f;
        logic        ch_f;
        n = (len == 16'd0) ? 1 : int'(len);
        for (int k = 0; k < n; k++) begin
            len_f = len;
            ch_f  = ch;
            if (k != 0 && noisy) begin
                len_f = 16'($urandom_range(65535, 0));
                ch_f  = 1'($urandom_range(1, 0));
            end
            send_item(8'($urandom_range(255, 0)), len_f, ch_f);
        end
        framed_items += n;
    endtask

    // Drain: stop sending, wait until every expected byte is out, then let the
    // pipeline go quiet. Pending is sampled on the falling edge to stay clear
    // of the checker's update at the rising one.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // Both registers, back to back. Only called with the block idle.
    task automatic write_config(input logic [7:0] cps, input logic [7:0] short_lim);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_CHUNK_PAYLOAD_SIZE;
        cfg_data <= cps;
        @(posedge clk);
        cfg_idx  <= CFG_SHORT_MESSAGE_LIMIT;
        cfg_data <= short_lim;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Mostly short messages so chunking, headers and raw frames all show up
    // often; an occasional zero length and a few longer ones.
    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) return 16'd0;
        if (r <= 7) return 16'($urandom_range(16, 1));
        return 16'($urandom_range(40, 17));
    endfunction

    task automatic random_phase();
        int          n_msgs;
        logic [7:0]  cps;
        logic [7:0]  short_lim;
        case ($urandom_range(5, 0))
            0: begin
                cps       = 8'($urandom_range(4, 1));
                short_lim = 8'($urandom_range(3, 0));
            end
            1: begin
                cps       = 8'($urandom_range(8, 1));
                short_lim = 8'($urandom_range(12, 0));
            end
            2: begin
                cps       = 8'd255;
                short_lim = 8'd0;
            end
            3: begin
                cps       = 8'd0;
                short_lim = 8'($urandom_range(6, 0));
            end
            4: begin
                cps       = 8'($urandom_range(255, 1));
                short_lim = 8'd255;
            end
            default: begin
                cps       = 8'($urandom_range(20, 1));
                short_lim = 8'($urandom_range(30, 0));
            end
        endcase
        case ($urandom_range(2, 0))
            0: idle_pct <= 0;
            1: idle_pct <= 15;
            default: idle_pct <= 35;
        endcase
        settle();
        write_config(cps, short_lim);
        n_msgs = $urandom_range(6, 2);
        repeat (n_msgs) begin
            send_message(pick_length(), 1'($urandom_range(1, 0)),
                         $urandom_range(2, 0) == 0);
        end
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        idle_pct     = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        framed_items = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct <= 25;

        // --- Directed part, reset registers (160 / 20) ---
        // raw frame of one byte, then a zero length that must act as one
        send_message(16'd1, 1'b0, 1'b0);
        send_message(16'd0, 1'b1, 1'b0);
        // length and channel latch on the first byte: the rest carry
        // all-ones and all-zeros lengths and a flipped channel
        send_item(8'($urandom_range(255, 0)), 16'd3, 1'b1);
        send_item(8'($urandom_range(255, 0)), 16'hFFFF, 1'b0);
        send_item(8'($urandom_range(255, 0)), 16'h0000, 1'b0);

        // zero payload size acts as one; short limit zero chunks everything
        settle();
        write_config(8'd0, 8'd0);
        send_message(16'd2, 1'b1, 1'b0);
        send_message(16'd0, 1'b0, 1'b0);

        // raw right at the limit, then chunked with a short final chunk
        settle();
        write_config(8'd3, 8'd4);
        send_message(16'd4, 1'b0, 1'b1);
        send_message(16'd5, 1'b1, 1'b0);
        send_message(16'd7, 1'b0, 1'b1);

        // both registers at their top value
        settle();
        write_config(8'd255, 8'd255);
        send_message(16'd2, 1'b1, 1'b0);

        // --- Random part ---
        framed_items = 0;
        while (framed_items < RANDOM_ITEMS) random_phase();

        // --- Final part, no idling on either side ---
        idle_pct <= 0;
        settle();
        write_config(8'd1, 8'd0);
        // 256 chunks needed: overflow, and no message id may be used up
        send_message(16'd256, 1'b1, 1'b1);
        send_message(16'd3, 1'b0, 1'b0);
        settle();
        write_config(8'($urandom_range(12, 1)), 8'($urandom_range(8, 0)));
        repeat (2) send_message(pick_length(), 1'($urandom_range(1, 0)), 1'b0);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_message_chunk_framer_top: PASS");
        end else begin
            $display("tb_message_chunk_framer_top: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mcf_pkg.sv
hw/rtl/mcf_if.sv
hw/rtl/mcf_div.sv
hw/rtl/mcf_front.sv
hw/rtl/mcf_queue.sv
hw/rtl/mcf_back.sv
hw/rtl/message_chunk_framer_top.sv
dv/mcf_frame_checker.sv
dv/tb_message_chunk_framer_top.sv
